// ----- rtl/ovfsv_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ovfsv_pkg: shared constants, types and sine table function for the V/f SVPWM drive
// Holds parameter defaults, register indexes and the Q15 quarter-wave sine function.
// ---------------------------------------------------------------------------
package ovfsv_pkg;
   localparam int NUM_MOTORS_DEF      = 2;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int PHASE_BITS_DEF      = 16;

   localparam logic [2:0] REG_RAMP_STEP = 3'd0;
   localparam logic [2:0] REG_PHASE_GAIN = 3'd1;
   localparam logic [2:0] REG_STOP_SPEED = 3'd2;
   localparam logic [2:0] REG_START_MV = 3'd3;
   localparam logic [2:0] REG_SLOPE_MV = 3'd4;
   localparam logic [2:0] REG_LIMIT_MV = 3'd5;
   localparam logic [2:0] REG_BUS_MV = 3'd6;
   localparam logic [2:0] REG_TIMER_TOP = 3'd7;

   localparam logic [15:0] SQRT3_HALF_Q15 = 16'd28378;
   localparam logic [15:0] BUS_MIN_MV = 16'd1000;

   typedef struct packed {
      logic [14:0] ramp_step;
      logic [15:0] phase_gain;
      logic [14:0] stop_speed;
      logic [15:0] start_mv;
      logic [15:0] slope_mv;
      logic [15:0] limit_mv;
      logic [15:0] bus_mv;
      logic [15:0] timer_top;
   } cfg_type;

   // long division, shift and subtract
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo, rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Q15 sine of (pi/2)*i/2^tbits, Taylor evaluation in Q30.
   function automatic logic [15:0] sine_entry(input int i, input int tbits);
      logic [63:0] x, u, t, s, e;
      logic [63:0] divs [6];
      divs[0] = 64'd156; divs[1] = 64'd110; divs[2] = 64'd72;
      divs[3] = 64'd42; divs[4] = 64'd20; divs[5] = 64'd6;
      x = (64'(i) * 64'd1686629713) >> tbits;
      u = (x * x) >> 30;
      t = 64'd1 << 30;
      for (int k = 0; k < 6; k++) begin
         t = (64'd1 << 30) - udiv64((u * t) >> 30, divs[k]);
      end
      s = (x * t) >> 30;
      e = (s + 64'd16384) >> 15;
      if (e > 64'd32767) begin
         e = 64'd32767;
      end
      return e[15:0];
   endfunction
endpackage

// ----- rtl/ovfsv_state_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ovfsv_state_mem: per-motor speed and phase memory
// Synchronous memory with a registered read, with valid bits cleared at reset.
// ---------------------------------------------------------------------------
module ovfsv_state_mem #(
   parameter int NUM_MOTORS = ovfsv_pkg::NUM_MOTORS_DEF,
   parameter int PHASE_BITS = ovfsv_pkg::PHASE_BITS_DEF,
   localparam int AW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [AW-1:0]         rd_addr,
   output logic [15:0]           rd_speed,
   output logic [PHASE_BITS-1:0] rd_phase,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [15:0]           wr_speed,
   input  logic [PHASE_BITS-1:0] wr_phase
);
   import ovfsv_pkg::*;

   logic [15+PHASE_BITS:0] mem [NUM_MOTORS];
   logic [NUM_MOTORS-1:0]  valid_ff;
   logic [15+PHASE_BITS:0] rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_speed, wr_phase};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_speed = rd_valid_ff ? rd_data_ff[15+PHASE_BITS:PHASE_BITS] : '0;
   assign rd_phase = rd_valid_ff ? rd_data_ff[PHASE_BITS-1:0] : '0;
endmodule

// ----- rtl/ovfsv_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ovfsv_datapath: sequenced ramp, phase, V/f, scaling and SVPWM datapath
// One-hot sequencer over registered steps; shares one bus divider.
// ---------------------------------------------------------------------------
module ovfsv_datapath #(
   parameter int NUM_MOTORS      = ovfsv_pkg::NUM_MOTORS_DEF,
   parameter int SINE_TABLE_BITS = ovfsv_pkg::SINE_TABLE_BITS_DEF,
   parameter int PHASE_BITS      = ovfsv_pkg::PHASE_BITS_DEF,
   localparam int AW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ovfsv_pkg::cfg_type    cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_motor_select,
   input  logic signed [15:0]    req_target_speed,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_motor_echo,
   output logic [15:0]           rsp_duty_a,
   output logic [15:0]           rsp_duty_b,
   output logic [15:0]           rsp_duty_c,
   output logic signed [15:0]    rsp_ramped_speed,
   output logic [AW-1:0]         mem_rd_addr,
   input  logic [15:0]           mem_rd_speed,
   input  logic [PHASE_BITS-1:0] mem_rd_phase,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [15:0]           mem_wr_speed,
   output logic [PHASE_BITS-1:0] mem_wr_phase
);
   import ovfsv_pkg::*;

   localparam int TN = 1 << SINE_TABLE_BITS;
   localparam int FB = PHASE_BITS - 2;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_READ  = 8'b00000010,
      ST_RAMP  = 8'b00000100,
      ST_PHASE = 8'b00001000,
      ST_VOLT  = 8'b00010000,
      ST_DIV   = 8'b00100000,
      ST_TRIG  = 8'b01000000,
      ST_MIX   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic       sel_ff;
   logic signed [15:0] target_ff;
   logic signed [15:0] spd_ff;
   logic [PHASE_BITS-1:0] phase_old_ff, phase_ff;
   logic [16:0] volt_ff;
   logic [47:0] num_ff;
   logic [47:0] rem_ff;
   logic [47:0] quo_ff;
   logic [5:0]  cnt_ff;
   logic signed [16:0] sin_ff, cos_ff;
   logic signed [63:0] va_ff, vb_ff, vc_ff;
   logic signed [63:0] pc_ff, ps_ff;
   logic [1:0]  trig_ff;
   logic        out_valid_ff;
   logic [15:0] duty_a_ff, duty_b_ff, duty_c_ff;
   logic        echo_ff;
   logic signed [15:0] out_spd_ff;
   logic [AW-1:0] maddr_ff;
   logic [AW-1:0] sel_addr;

   // ramp
   logic signed [17:0] diff, stp;
   logic signed [15:0] spd_new;
   always_comb begin
      stp = 18'(cfg.ramp_step);
      diff = 18'(target_ff) - 18'(signed'(mem_rd_speed));
      if (diff > stp) begin
         spd_new = 16'(18'(signed'(mem_rd_speed)) + stp);
      end else if (diff < -stp) begin
         spd_new = 16'(18'(signed'(mem_rd_speed)) - stp);
      end else begin
         spd_new = target_ff;
      end
   end

   // phase increment, arithmetic shift gives floor
   logic signed [32:0] prod;
   logic [PHASE_BITS-1:0] phase_new;
   assign prod = 33'(spd_ff) * signed'({1'b0, cfg.phase_gain});
   assign phase_new = phase_old_ff + PHASE_BITS'(prod >>> 8);

   // V/f
   logic [15:0] mag;
   logic [31:0] slope_prod;
   logic [24:0] vsum;
   assign mag = spd_ff[15] ? 16'(-spd_ff) : 16'(spd_ff);
   assign slope_prod = mag * cfg.slope_mv;
   assign vsum = 25'(cfg.start_mv) + 25'(slope_prod >> 8);

   // bus divider, restoring, one bit a cycle
   logic [15:0] bus;
   logic [48:0] trial;
   assign bus = (cfg.bus_mv < BUS_MIN_MV) ? BUS_MIN_MV : cfg.bus_mv;
   assign trial = {rem_ff, num_ff[47]} - 49'(bus);

   // quarter-wave sine table, registered read
   logic [15:0] sine_rom [TN+1];
   initial begin
      for (int i = 0; i <= TN; i++) begin
         sine_rom[i] = sine_entry(i, SINE_TABLE_BITS);
      end
   end

   function automatic logic [SINE_TABLE_BITS:0] rom_pos(input logic [PHASE_BITS-1:0] ph);
      logic [FB-1:0] frac;
      logic [SINE_TABLE_BITS-1:0] idx;
      frac = ph[FB-1:0];
      if (FB >= SINE_TABLE_BITS) begin
         idx = SINE_TABLE_BITS'(frac >> (FB - SINE_TABLE_BITS));
      end else begin
         idx = SINE_TABLE_BITS'({frac, {SINE_TABLE_BITS{1'b0}}} >> FB);
      end
      return ph[FB] ? (SINE_TABLE_BITS+1)'(TN) - {1'b0, idx} : {1'b0, idx};
   endfunction

   logic [PHASE_BITS-1:0] quarter;
   logic [PHASE_BITS-1:0] cos_phase;
   logic [SINE_TABLE_BITS:0] sin_pos, cos_pos;
   logic [15:0] sin_rd_ff, cos_rd_ff;
   assign quarter = PHASE_BITS'(1) << (PHASE_BITS - 2);
   assign cos_phase = phase_ff + quarter;
   assign sin_pos = rom_pos(phase_ff);
   assign cos_pos = rom_pos(cos_phase);

   always_ff @(posedge clock) begin
      sin_rd_ff <= sine_rom[sin_pos];
      cos_rd_ff <= sine_rom[cos_pos];
   end

   // min-max midpoint and duties
   logic signed [63:0] hi, lo;
   always_comb begin
      hi = va_ff;
      if (vb_ff > hi) hi = vb_ff;
      if (vc_ff > hi) hi = vc_ff;
      lo = va_ff;
      if (vb_ff < lo) lo = vb_ff;
      if (vc_ff < lo) lo = vc_ff;
   end

   function automatic logic [15:0] duty_of(input logic signed [63:0] x,
         input logic signed [63:0] h, input logic signed [63:0] l,
         input logic [15:0] per);
      logic signed [65:0] n;
      logic [26:0] q;
      n = (66'(x) - 66'(h)) + (66'(x) - 66'(l)) + (66'({1'b0, per}) <<< 38);
      q = 27'(n >>> 39);
      if (n < 0) begin
         return 16'd0;
      end else if (q > 27'(per)) begin
         return per;
      end else begin
         return q[15:0];
      end
   endfunction

   assign req_stall = (state_ff != ST_IDLE) || out_valid_ff;
   assign sel_addr = (NUM_MOTORS > 1) ? AW'(req_motor_select) : '0;
   assign mem_rd_addr = (state_ff == ST_IDLE) ? sel_addr : maddr_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid && !req_stall) state_in = ST_READ;
         ST_READ:  state_in = ST_RAMP;
         ST_RAMP:  state_in = ST_PHASE;
         ST_PHASE: state_in = ST_VOLT;
         ST_VOLT:  state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 6'd47) state_in = ST_TRIG;
         ST_TRIG:  if (trig_ff == 2'd2) state_in = ST_MIX;
         ST_MIX:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign mem_wr_en = (state_ff == ST_PHASE);
   assign mem_wr_addr = maddr_ff;
   assign mem_wr_speed = spd_ff;
   assign mem_wr_phase = phase_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MIX) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            sel_ff <= req_motor_select;
            target_ff <= req_target_speed;
            maddr_ff <= sel_addr;
         end
         ST_READ: begin
         end
         ST_RAMP: begin
            spd_ff <= spd_new;
            phase_old_ff <= mem_rd_phase;
         end
         ST_PHASE: begin
            phase_ff <= phase_new;
            if (mag < 16'(cfg.stop_speed)) begin
               volt_ff <= '0;
            end else if (vsum > 25'(cfg.limit_mv)) begin
               volt_ff <= 17'(cfg.limit_mv);
            end else begin
               volt_ff <= 17'(vsum);
            end
         end
         ST_VOLT: begin
            num_ff <= 48'(volt_ff * cfg.timer_top) << 9;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV: begin
            if (!trial[48]) begin
               rem_ff <= trial[47:0];
               quo_ff <= {quo_ff[46:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[46:0], num_ff[47]};
               quo_ff <= {quo_ff[46:0], 1'b0};
            end
            num_ff <= {num_ff[46:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
            trig_ff <= '0;
            sin_ff <= phase_ff[PHASE_BITS-1] ? -signed'({1'b0, sin_rd_ff}) :
                      signed'({1'b0, sin_rd_ff});
            cos_ff <= cos_phase[PHASE_BITS-1] ? -signed'({1'b0, cos_rd_ff}) :
                      signed'({1'b0, cos_rd_ff});
         end
         ST_TRIG: begin
            trig_ff <= trig_ff + 2'd1;
            if (trig_ff == 2'd0) begin
               pc_ff <= 64'(signed'({1'b0, quo_ff[33:0]})) * 64'(cos_ff);
               ps_ff <= 64'(signed'({1'b0, quo_ff[33:0]})) * 64'(sin_ff);
            end else if (trig_ff == 2'd1) begin
               va_ff <= pc_ff <<< 15;
               vb_ff <= ps_ff * 64'(SQRT3_HALF_Q15);
               vc_ff <= -(pc_ff <<< 14);
            end else begin
               vb_ff <= vb_ff - (pc_ff <<< 14);
               vc_ff <= vc_ff - vb_ff;
            end
         end
         ST_MIX: begin
            duty_a_ff <= duty_of(va_ff, hi, lo, cfg.timer_top);
            duty_b_ff <= duty_of(vb_ff, hi, lo, cfg.timer_top);
            duty_c_ff <= duty_of(vc_ff, hi, lo, cfg.timer_top);
            echo_ff <= sel_ff;
            out_spd_ff <= spd_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_motor_echo = echo_ff;
   assign rsp_duty_a = duty_a_ff;
   assign rsp_duty_b = duty_b_ff;
   assign rsp_duty_c = duty_c_ff;
   assign rsp_ramped_speed = out_spd_ff;
endmodule

// ----- rtl/open_loop_vf_svpwm_drive.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// open_loop_vf_svpwm_drive: open-loop V/f drive with min-max SVPWM
// Ramps per-motor speed, advances phase, and produces three clamped duties.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries a motor index and a
//   signed target speed. Response channel (rsp_valid/rsp_stall) returns the
//   motor index, three compare values and the ramped speed.
//   One request is in flight at a time. rsp_valid rises after the accepted
//   request has gone through a state memory read, ramp and phase steps,
//   a bit-serial divide by the bus voltage, three trig steps and the
//   duty mix. The divider sets the rate: with no receiver stall a new
//   request is accepted only after the previous response has been taken.
//   The next request is taken once the response register is empty.
//   While rsp_stall is high the response holds and req_stall stays high.
//   Reset returns the configuration registers, the sequencer and rsp_valid
//   to their reset values and marks every motor's speed and phase as zero through valid bits.
//   Configuration writes through csr_* take effect at once; write only
//   while no request is in flight.
// ---------------------------------------------------------------------------
module open_loop_vf_svpwm_drive #(
   parameter int NUM_MOTORS      = ovfsv_pkg::NUM_MOTORS_DEF,
   parameter int SINE_TABLE_BITS = ovfsv_pkg::SINE_TABLE_BITS_DEF,
   parameter int PHASE_BITS      = ovfsv_pkg::PHASE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_motor_select,
   input  logic signed [15:0] req_target_speed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_motor_echo,
   output logic [15:0]        rsp_duty_a,
   output logic [15:0]        rsp_duty_b,
   output logic [15:0]        rsp_duty_c,
   output logic signed [15:0] rsp_ramped_speed
);
   import ovfsv_pkg::*;

   localparam int AW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   cfg_type cfg_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [15:0] rd_speed, wr_speed;
   logic [PHASE_BITS-1:0] rd_phase, wr_phase;
   logic wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step <= 15'd1;
         cfg_ff.phase_gain <= 16'd280;
         cfg_ff.stop_speed <= 15'd10;
         cfg_ff.start_mv <= 16'd1000;
         cfg_ff.slope_mv <= 16'd512;
         cfg_ff.limit_mv <= 16'd5920;
         cfg_ff.bus_mv <= 16'd7400;
         cfg_ff.timer_top <= 16'd9999;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RAMP_STEP:  cfg_ff.ramp_step <= csr_data[14:0];
            REG_PHASE_GAIN: cfg_ff.phase_gain <= csr_data;
            REG_STOP_SPEED: cfg_ff.stop_speed <= csr_data[14:0];
            REG_START_MV:   cfg_ff.start_mv <= csr_data;
            REG_SLOPE_MV:   cfg_ff.slope_mv <= csr_data;
            REG_LIMIT_MV:   cfg_ff.limit_mv <= csr_data;
            REG_BUS_MV:     cfg_ff.bus_mv <= csr_data;
            REG_TIMER_TOP:  cfg_ff.timer_top <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ovfsv_state_mem #(.NUM_MOTORS(NUM_MOTORS), .PHASE_BITS(PHASE_BITS)) u_mem (
      .clock(clock), .reset(reset),
      .rd_addr(rd_addr), .rd_speed(rd_speed), .rd_phase(rd_phase),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_speed(wr_speed), .wr_phase(wr_phase)
   );

   ovfsv_datapath #(
      .NUM_MOTORS(NUM_MOTORS), .SINE_TABLE_BITS(SINE_TABLE_BITS),
      .PHASE_BITS(PHASE_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_motor_select(req_motor_select), .req_target_speed(req_target_speed),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_motor_echo(rsp_motor_echo), .rsp_duty_a(rsp_duty_a),
      .rsp_duty_b(rsp_duty_b), .rsp_duty_c(rsp_duty_c),
      .rsp_ramped_speed(rsp_ramped_speed),
      .mem_rd_addr(rd_addr), .mem_rd_speed(rd_speed), .mem_rd_phase(rd_phase),
      .mem_wr_en(wr_en), .mem_wr_addr(wr_addr), .mem_wr_speed(wr_speed),
      .mem_wr_phase(wr_phase)
   );
endmodule

// ----- sim/tb_open_loop_vf_svpwm_drive.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_open_loop_vf_svpwm_drive: self-checking bench for the V/f SVPWM drive
// Sends motor speed requests under several register settings and random
// stalls on both channels. A local model of the ramp, phase, V/f and min-max
// duty math predicts every response, which is compared field by field.
// ---------------------------------------------------------------------------
module tb_open_loop_vf_svpwm_drive;
   import ovfsv_pkg::*;

   typedef struct {
      logic               motor;
      logic [15:0]        duty_a;
      logic [15:0]        duty_b;
      logic [15:0]        duty_c;
      logic signed [15:0] speed;
   } duty_set_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_motor_select = 1'b0;
   logic signed [15:0] req_target_speed = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_motor_echo;
   logic [15:0]        rsp_duty_a, rsp_duty_b, rsp_duty_c;
   logic signed [15:0] rsp_ramped_speed;

   duty_set_type       pending_duties[$];
   int                 errors = 0;
   int                 idle_mode = 2;
   int                 hold_left = 0;
   int                 quiet_cycles = 0;
   int                 sine_lut[0:1024];
   logic [15:0]        reg_val[8];
   logic signed [15:0] motor_speed[2];
   logic [15:0]        motor_phase[2];

   open_loop_vf_svpwm_drive uut (.*);

   always #4 clock = ~clock;

   function automatic void build_sine_lut();
      longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
      longint unsigned x, u, t, s, e;
      for (int i = 0; i <= 1024; i++) begin
         x = longint'(i) * 64'd1686629713 / 1024;
         u = (x * x) >> 30;
         t = 64'd1 << 30;
         for (int k = 0; k < 6; k++) t = (64'd1 << 30) - ((u * t) >> 30) / divs[k];
         s = (x * t) >> 30;
         e = (s + 64'd16384) >> 15;
         if (e > 32767) e = 32767;
         sine_lut[i] = int'(e);
      end
   endfunction

   function automatic int lut_sine(logic [15:0] ph);
      int idx, v;
      idx = (ph[13:0] >> 4) & 1023;
      v = ph[14] ? sine_lut[1024 - idx] : sine_lut[idx];
      return ph[15] ? -v : v;
   endfunction

   function automatic logic [15:0] mix_duty(logic signed [95:0] x, logic signed [95:0] hi,
                                            logic signed [95:0] lo, longint per);
      logic signed [95:0] n, q;
      n = (x - hi) + (x - lo) + (96'(per) <<< 38);
      if (n < 0) return 16'd0;
      q = n >>> 39;
      return (q > per) ? per[15:0] : q[15:0];
   endfunction

   function automatic duty_set_type predict_duties(logic sel, logic signed [15:0] target);
      duty_set_type r;
      int spd, diff, step, mag, cs, sn;
      longint prod, volt, bus, per, amp;
      logic signed [95:0] pc, ps, va, vb, vc, hi, lo;
      step = reg_val[REG_RAMP_STEP] & 16'h7FFF;
      spd = motor_speed[sel];
      diff = int'(target) - spd;
      if (diff > step) spd += step;
      else if (diff < -step) spd -= step;
      else spd = target;
      motor_speed[sel] = spd[15:0];
      prod = longint'(spd) * longint'(reg_val[REG_PHASE_GAIN]);
      motor_phase[sel] = motor_phase[sel] + 16'(prod >>> 8);
      mag = spd < 0 ? -spd : spd;
      if (mag < (reg_val[REG_STOP_SPEED] & 16'h7FFF)) begin
         volt = 0;
      end else begin
         volt = reg_val[REG_START_MV] + ((longint'(mag) * reg_val[REG_SLOPE_MV]) >> 8);
         if (volt > reg_val[REG_LIMIT_MV]) volt = reg_val[REG_LIMIT_MV];
      end
      bus = reg_val[REG_BUS_MV] < 1000 ? 1000 : reg_val[REG_BUS_MV];
      per = reg_val[REG_TIMER_TOP];
      amp = volt * per * 512 / bus;
      cs = lut_sine(motor_phase[sel] + 16'h4000);
      sn = lut_sine(motor_phase[sel]);
      pc = 96'(amp) * cs;
      ps = 96'(amp) * sn;
      va = pc * 32768;
      vb = -pc * 16384 + ps * 28378;
      vc = -pc * 16384 - ps * 28378;
      hi = va; if (vb > hi) hi = vb; if (vc > hi) hi = vc;
      lo = va; if (vb < lo) lo = vb; if (vc < lo) lo = vc;
      r.motor = sel;
      r.duty_a = mix_duty(va, hi, lo, per);
      r.duty_b = mix_duty(vb, hi, lo, per);
      r.duty_c = mix_duty(vc, hi, lo, per);
      r.speed = spd[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // response check, receiver stalls and watchdog
   always @(posedge clock) begin
      duty_set_type w;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > 6000) begin
            $display("Simulation FAILED");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_duties.size() == 0) begin
               report_mismatch("unexpected response", rsp_duty_a, 0);
            end else begin
               w = pending_duties.pop_front();
               if (rsp_motor_echo !== w.motor)
                  report_mismatch("motor_echo", rsp_motor_echo, w.motor);
               if (rsp_duty_a !== w.duty_a) report_mismatch("duty_a", rsp_duty_a, w.duty_a);
               if (rsp_duty_b !== w.duty_b) report_mismatch("duty_b", rsp_duty_b, w.duty_b);
               if (rsp_duty_c !== w.duty_c) report_mismatch("duty_c", rsp_duty_c, w.duty_c);
               if (rsp_ramped_speed !== w.speed)
                  report_mismatch("ramped_speed", rsp_ramped_speed, w.speed);
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (idle_mode == 0) ? ($urandom_range(99) < 49) :
                      (idle_mode == 1) ? ($urandom_range(99) < 28) : 1'b0;
      end
   end

   task automatic send_request(logic sel, logic signed [15:0] target);
      @(posedge clock);
      while ((idle_mode == 0 && $urandom_range(99) < 28) ||
             (idle_mode == 1 && $urandom_range(99) < 49)) @(posedge clock);
      req_valid <= 1'b1;
      req_motor_select <= sel;
      req_target_speed <= target;
      do @(posedge clock); while (req_stall);
      pending_duties.push_back(predict_duties(sel, target));
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      reg_val[idx] = val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_speed();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(40)) - 16'sd20;
         2: return 16'($urandom_range(4000)) - 16'sd2000;
         default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      endcase
   endfunction

   task automatic random_config();
      write_reg(REG_RAMP_STEP, $urandom_range(3) == 0 ? 16'h7FFF : 16'($urandom_range(3000)));
      write_reg(REG_PHASE_GAIN, 16'($urandom));
      write_reg(REG_STOP_SPEED, 16'($urandom_range(50)));
      write_reg(REG_START_MV, 16'($urandom));
      write_reg(REG_SLOPE_MV, 16'($urandom));
      write_reg(REG_LIMIT_MV, 16'($urandom));
      write_reg(REG_BUS_MV, $urandom_range(7) == 0 ? 16'($urandom_range(999)) :
                            16'($urandom_range(65535, 1000)));
      write_reg(REG_TIMER_TOP, $urandom_range(7) == 0 ? 16'd0 : 16'($urandom));
   endtask

   task automatic test_default_registers();
      send_request(1'b0, 16'sd0);
      send_request(1'b1, 16'sh7FFF);
      send_request(1'b1, 16'sh8000);
      send_request(1'b0, 16'sd5);
      repeat (4) send_request(1'b0, 16'sd20);
      drain();
   endtask

   task automatic test_register_extremes();
      write_reg(REG_RAMP_STEP, 16'h7FFF);
      write_reg(REG_PHASE_GAIN, 16'hFFFF);
      write_reg(REG_STOP_SPEED, 16'd0);
      write_reg(REG_START_MV, 16'hFFFF);
      write_reg(REG_SLOPE_MV, 16'hFFFF);
      write_reg(REG_LIMIT_MV, 16'hFFFF);
      write_reg(REG_BUS_MV, 16'd1000);
      write_reg(REG_TIMER_TOP, 16'hFFFF);
      send_request(1'b0, 16'sh7FFF);
      send_request(1'b1, 16'sh8000);
      send_request(1'b0, 16'sh8000);
      send_request(1'b1, 16'sd0);
      drain();
      write_reg(REG_LIMIT_MV, 16'd200);
      write_reg(REG_BUS_MV, 16'd300);
      write_reg(REG_STOP_SPEED, 16'h7FFF);
      send_request(1'b0, 16'sh7FFF);
      send_request(1'b0, -16'sd1234);
      drain();
      write_reg(REG_STOP_SPEED, 16'd0);
      write_reg(REG_TIMER_TOP, 16'd0);
      send_request(1'b1, 16'sd1000);
      drain();
      write_reg(REG_TIMER_TOP, 16'd1);
      write_reg(REG_RAMP_STEP, 16'd0);
      write_reg(REG_PHASE_GAIN, 16'd0);
      write_reg(REG_START_MV, 16'd0);
      write_reg(REG_SLOPE_MV, 16'd0);
      send_request(1'b1, 16'sd1000);
      send_request(1'b0, -16'sd1000);
      drain();
   endtask

   task automatic test_random_traffic();
      for (int mode = 0; mode < 3; mode++) begin
         idle_mode = mode;
         for (int chunk = 0; chunk < 10; chunk++) begin
            random_config();
            repeat (54) send_request(1'($urandom), pick_speed());
            drain();
         end
      end
   endtask

   task automatic test_backpressure();
      idle_mode = 2;
      hold_left = 600;
      repeat (20) send_request(1'($urandom), pick_speed());
      drain();
   endtask

   initial begin
      build_sine_lut();
      reg_val = '{16'd1, 16'd280, 16'd10, 16'd1000, 16'd512, 16'd5920, 16'd7400, 16'd9999};
      motor_speed = '{16'sd0, 16'sd0};
      motor_phase = '{16'd0, 16'd0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();
      repeat (100) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
